// File: sv/modular_combinatorics_unit_macros.svh
// ---------------------------------------------------------------------------
// modular_combinatorics_unit_macros.svh
// Assertion macros of the modular combinatorics unit, used by mcu_modmul.
// ---------------------------------------------------------------------------
`ifndef MODULAR_COMBINATORICS_UNIT_MACROS_SVH
`define MODULAR_COMBINATORICS_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcu assertion failed");

// next-cycle implication
`define MCU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcu assertion failed");

`endif

// File: sv/mcu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcu_pkg
// Types and constants of the modular combinatorics unit.
// ---------------------------------------------------------------------------
package mcu_pkg;

	localparam int unsigned ModW = 31;
	localparam int unsigned ArgW = 32;
	localparam logic [ModW-1:0] ModReset = 31'd1000000007;

	localparam logic [2:0] FnPow  = 3'd0;
	localparam logic [2:0] FnInv  = 3'd1;
	localparam logic [2:0] FnFact = 3'd2;
	localparam logic [2:0] FnNpr  = 3'd3;
	localparam logic [2:0] FnNcr  = 3'd4;
	localparam logic [2:0] FnNhr  = 3'd5;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_BLD_INIT,
		OP_BLD_ONE,
		OP_BLD_MUL,
		OP_POW_ARG,
		OP_POW_RD,
		OP_MUL_YB,
		OP_MUL_BB,
		OP_RD_N,
		OP_RD_D,
		OP_RD_R,
		OP_MUL_YRD,
		OP_MUL_VY,
		OP_V_Y,
		OP_V_RD,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		K_EARLY,
		K_POW,
		K_FACT,
		K_PC
	} kind_t;

	typedef enum logic [1:0] {
		D_BASE,
		D_Y,
		D_V,
		D_TBL
	} dest_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic  cfg_wr;
		logic  mul_done;
		logic  bld_small;
		logic  bld_done;
		logic  e_zero;
		logic  e_lsb;
		kind_t kind;
		logic  choose;
	} status_t;

endpackage

// File: sv/mcu_modmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcu_modmul
// Shift-add modular multiplier, one multiplier bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`include "modular_combinatorics_unit_macros.svh"

module mcu_modmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] a,
	input  logic [31:0] b,
	input  logic [30:0] m,
	output logic        done,
	output logic [30:0] result
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [30:0] a_q;
	logic [31:0] b_q;
	logic [30:0] m_q;
	logic [30:0] r_q;
	logic [31:0] dbl;
	logic [31:0] sum;

	always_comb begin
		dbl = {r_q, 1'b0};
		if (dbl >= {1'b0, m_q}) begin
			dbl = dbl - {1'b0, m_q};
		end
		sum = dbl + (b_q[31] ? {1'b0, a_q} : 32'd0);
		if (sum >= {1'b0, m_q}) begin
			sum = sum - {1'b0, m_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= sum[30:0];
			b_q <= {b_q[30:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = r_q;

	`MCU_ASSERT_NXT(a_start_busy, start, busy_q)
	`MCU_ASSERT_NXT(a_done_idle, done_q && !start, !busy_q)
	`MCU_ASSERT_IMP(a_rem_range, busy_q, r_q < m_q)

endmodule

// File: sv/mcu_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcu_dp
// Datapath: modulus register, factorial memory, operand decode, power
// registers and the shared modular multiplier.
// ---------------------------------------------------------------------------
module mcu_dp #(
	parameter int unsigned MAX_N = 4095
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcu_pkg::cmd_t       cmd,
	output mcu_pkg::status_t    status,
	input  logic [2:0]          func,
	input  logic [31:0]         arg_a,
	input  logic [31:0]         arg_b,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	output logic [31:0]         cfg_rdata,
	output logic [30:0]         value,
	output logic                range_error
);

	localparam int unsigned AW = $clog2(MAX_N + 1);
	localparam int unsigned KW = $clog2(MAX_N + 2);

	logic [30:0]   modulus_q;
	logic [30:0]   mem_q [MAX_N+1];
	logic [30:0]   rd_q;
	logic [KW-1:0] k_q;
	logic [30:0]   fprev_q;
	logic [31:0]   x_q;
	logic [30:0]   exp_q;
	logic [30:0]   e_q;
	logic [30:0]   y_q;
	logic [30:0]   base_q;
	logic [30:0]   v_q;
	logic          err_q;
	mcu_pkg::kind_t kind_q;
	logic          choose_q;
	logic [AW-1:0] n_q;
	logic [AW-1:0] d_q;
	logic [AW-1:0] r_q;
	mcu_pkg::dest_t dest_q;
	logic [30:0]   out_value_q;
	logic          out_err_q;

	logic          mul_start;
	logic [30:0]   mul_a;
	logic [31:0]   mul_b;
	mcu_pkg::dest_t mul_dest;
	logic          mul_done;
	logic [30:0]   mul_res;

	// decode
	logic          b_neg;
	logic          b_zero;
	logic          a_lt_b;
	logic          a_big;
	logic [33:0]   nh_n;
	logic          nh_big;
	logic [31:0]   am1;
	logic [31:0]   a_mb;
	mcu_pkg::kind_t dec_kind;
	logic          dec_v;
	logic          dec_err;
	logic          dec_choose;
	logic [30:0]   dec_exp;
	logic [AW-1:0] dec_n;
	logic [AW-1:0] dec_d;
	logic [AW-1:0] dec_r;
	logic [30:0]   wr_mod;
	logic [AW-1:0] rd_addr;

	always_comb begin
		b_neg  = arg_b[31];
		b_zero = (arg_b == 32'd0);
		a_lt_b = (arg_a < arg_b);
		a_big  = (arg_a > 32'(MAX_N));
		nh_n   = {2'b00, arg_a} - 34'd1 + {{2{arg_b[31]}}, arg_b};
		nh_big = (nh_n > 34'(MAX_N));
		am1    = arg_a - 32'd1;
		a_mb   = arg_a - arg_b;
		dec_kind   = mcu_pkg::K_EARLY;
		dec_v      = 1'b0;
		dec_err    = 1'b0;
		dec_choose = 1'b0;
		dec_exp    = modulus_q - 31'd2;
		dec_n      = arg_a[AW-1:0];
		dec_d      = a_mb[AW-1:0];
		dec_r      = arg_b[AW-1:0];
		case (func)
			mcu_pkg::FnPow: begin
				if (b_neg || b_zero) begin
					dec_v = 1'b1;
				end else begin
					dec_kind = mcu_pkg::K_POW;
					dec_exp  = arg_b[30:0];
				end
			end
			mcu_pkg::FnInv: begin
				dec_kind = mcu_pkg::K_POW;
			end
			mcu_pkg::FnFact: begin
				if (a_big) begin
					dec_err = 1'b1;
				end else begin
					dec_kind = mcu_pkg::K_FACT;
				end
			end
			mcu_pkg::FnNpr, mcu_pkg::FnNcr: begin
				if (b_neg || a_lt_b) begin
					dec_v = 1'b0;
				end else if (a_big) begin
					dec_err = 1'b1;
				end else begin
					dec_kind   = mcu_pkg::K_PC;
					dec_choose = (func == mcu_pkg::FnNcr);
				end
			end
			mcu_pkg::FnNhr: begin
				if (arg_a == 32'd0) begin
					dec_v = b_zero;
				end else if (b_neg) begin
					dec_v = 1'b0;
				end else if (nh_big) begin
					dec_err = 1'b1;
				end else begin
					dec_kind   = mcu_pkg::K_PC;
					dec_choose = 1'b1;
					dec_n      = nh_n[AW-1:0];
					dec_d      = arg_b[AW-1:0];
					dec_r      = am1[AW-1:0];
				end
			end
			default: begin
				dec_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = y_q;
		mul_b     = {1'b0, base_q};
		mul_dest  = mcu_pkg::D_Y;
		case (cmd.op)
			mcu_pkg::OP_BLD_MUL: begin
				mul_start = 1'b1;
				mul_a     = fprev_q;
				mul_b     = 32'(k_q);
				mul_dest  = mcu_pkg::D_TBL;
			end
			mcu_pkg::OP_POW_ARG: begin
				mul_start = 1'b1;
				mul_a     = 31'd1;
				mul_b     = x_q;
				mul_dest  = mcu_pkg::D_BASE;
			end
			mcu_pkg::OP_POW_RD: begin
				mul_start = 1'b1;
				mul_a     = 31'd1;
				mul_b     = {1'b0, rd_q};
				mul_dest  = mcu_pkg::D_BASE;
			end
			mcu_pkg::OP_MUL_YB: begin
				mul_start = 1'b1;
			end
			mcu_pkg::OP_MUL_BB: begin
				mul_start = 1'b1;
				mul_a     = base_q;
				mul_dest  = mcu_pkg::D_BASE;
			end
			mcu_pkg::OP_MUL_YRD: begin
				mul_start = 1'b1;
				mul_b     = {1'b0, rd_q};
				mul_dest  = mcu_pkg::D_V;
			end
			mcu_pkg::OP_MUL_VY: begin
				mul_start = 1'b1;
				mul_a     = v_q;
				mul_b     = {1'b0, y_q};
				mul_dest  = mcu_pkg::D_V;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mcu_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (modulus_q),
		.done   (mul_done),
		.result (mul_res)
	);

	always_comb begin
		wr_mod = cfg_wdata[30:0];
		if (wr_mod < 31'd2) begin
			wr_mod = 31'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mcu_pkg::ModReset;
			k_q       <= '0;
		end else begin
			if (cfg_we) begin
				modulus_q <= wr_mod;
			end
			if (cmd.op == mcu_pkg::OP_BLD_INIT) begin
				k_q <= '0;
			end else if (cmd.op == mcu_pkg::OP_BLD_ONE) begin
				k_q <= k_q + 1'b1;
			end else if (mul_done && dest_q == mcu_pkg::D_TBL) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// factorial memory
	always_comb begin
		case (cmd.op)
			mcu_pkg::OP_RD_D: rd_addr = d_q;
			mcu_pkg::OP_RD_R: rd_addr = r_q;
			default:          rd_addr = n_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mcu_pkg::OP_BLD_ONE) begin
			mem_q[k_q[AW-1:0]] <= 31'd1;
		end else if (mul_done && dest_q == mcu_pkg::D_TBL) begin
			mem_q[k_q[AW-1:0]] <= mul_res;
		end
		if (cmd.op == mcu_pkg::OP_RD_N || cmd.op == mcu_pkg::OP_RD_D
				|| cmd.op == mcu_pkg::OP_RD_R) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			dest_q <= mul_dest;
		end
		if (cmd.op == mcu_pkg::OP_BLD_INIT) begin
			fprev_q <= 31'd1;
		end else if (mul_done && dest_q == mcu_pkg::D_TBL) begin
			fprev_q <= mul_res;
		end
		if (cmd.op == mcu_pkg::OP_LOAD) begin
			x_q      <= arg_a;
			exp_q    <= dec_exp;
			kind_q   <= dec_kind;
			choose_q <= dec_choose;
			n_q      <= dec_n;
			d_q      <= dec_d;
			r_q      <= dec_r;
			err_q    <= dec_err;
		end
		if (cmd.op == mcu_pkg::OP_POW_ARG || cmd.op == mcu_pkg::OP_POW_RD) begin
			y_q <= 31'd1;
			e_q <= exp_q;
		end else if (cmd.op == mcu_pkg::OP_MUL_BB) begin
			e_q <= {1'b0, e_q[30:1]};
		end
		if (cmd.op == mcu_pkg::OP_LOAD) begin
			v_q <= {30'd0, dec_v};
		end else if (cmd.op == mcu_pkg::OP_V_Y) begin
			v_q <= y_q;
		end else if (cmd.op == mcu_pkg::OP_V_RD) begin
			v_q <= rd_q;
		end
		if (mul_done) begin
			case (dest_q)
				mcu_pkg::D_BASE: base_q <= mul_res;
				mcu_pkg::D_Y:    y_q    <= mul_res;
				mcu_pkg::D_V:    v_q    <= mul_res;
				default:         ;
			endcase
		end
		if (cmd.op == mcu_pkg::OP_OUT) begin
			out_value_q <= v_q;
			out_err_q   <= err_q;
		end
	end

	always_comb begin
		status.cfg_wr    = cfg_we;
		status.mul_done  = mul_done;
		status.bld_small = (k_q < KW'(2));
		status.bld_done  = (k_q == KW'(MAX_N + 1));
		status.e_zero    = (e_q == 31'd0);
		status.e_lsb     = e_q[0];
		status.kind      = kind_q;
		status.choose    = choose_q;
	end

	assign cfg_rdata   = {1'b0, modulus_q};
	assign value       = out_value_q;
	assign range_error = out_err_q;

endmodule

// File: sv/mcu_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcu_ctrl
// Controller: table build sweep, operation sequencing, output handshake.
// ---------------------------------------------------------------------------
module mcu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  mcu_pkg::status_t status,
	output mcu_pkg::cmd_t    cmd,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready
);

	typedef enum logic [4:0] {
		S_BINIT,
		S_BCHK,
		S_BWAIT,
		S_IDLE,
		S_DISP,
		S_FACT,
		S_PRED,
		S_PRWAIT,
		S_PCHK,
		S_PYWAIT,
		S_PSQ,
		S_PBWAIT,
		S_VY,
		S_RDN,
		S_MULYRD,
		S_MWAIT1,
		S_RDR,
		S_MULVY,
		S_MWAIT2,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		R_POW,
		R_INV1,
		R_INV2
	} ret_t;

	state_t state_q;
	ret_t   ret_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.op = mcu_pkg::OP_NOP;
		case (state_q)
			S_BINIT: cmd.op = mcu_pkg::OP_BLD_INIT;
			S_BCHK: begin
				if (status.bld_done) begin
					cmd.op = mcu_pkg::OP_NOP;
				end else if (status.bld_small) begin
					cmd.op = mcu_pkg::OP_BLD_ONE;
				end else begin
					cmd.op = mcu_pkg::OP_BLD_MUL;
				end
			end
			S_IDLE: begin
				if (in_valid && !status.cfg_wr) begin
					cmd.op = mcu_pkg::OP_LOAD;
				end
			end
			S_DISP: begin
				case (status.kind)
					mcu_pkg::K_FACT: cmd.op = mcu_pkg::OP_RD_N;
					mcu_pkg::K_PC:   cmd.op = mcu_pkg::OP_RD_D;
					default:         cmd.op = mcu_pkg::OP_NOP;
				endcase
			end
			S_FACT:   cmd.op = mcu_pkg::OP_V_RD;
			S_PRED:   cmd.op = (ret_q == R_POW) ? mcu_pkg::OP_POW_ARG : mcu_pkg::OP_POW_RD;
			S_PCHK: begin
				if (!status.e_zero && status.e_lsb) begin
					cmd.op = mcu_pkg::OP_MUL_YB;
				end
			end
			S_PSQ:    cmd.op = mcu_pkg::OP_MUL_BB;
			S_VY:     cmd.op = mcu_pkg::OP_V_Y;
			S_RDN:    cmd.op = mcu_pkg::OP_RD_N;
			S_MULYRD: cmd.op = mcu_pkg::OP_MUL_YRD;
			S_RDR:    cmd.op = mcu_pkg::OP_RD_R;
			S_MULVY:  cmd.op = mcu_pkg::OP_MUL_VY;
			S_DONE: begin
				if (out_free) begin
					cmd.op = mcu_pkg::OP_OUT;
				end
			end
			default:  cmd.op = mcu_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BINIT;
			ret_q       <= R_POW;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready)
				|| (state_q == S_DONE && out_free && !status.cfg_wr);
			if (status.cfg_wr) begin
				state_q <= S_BINIT;
			end else begin
				case (state_q)
					S_BINIT: state_q <= S_BCHK;
					S_BCHK: begin
						if (status.bld_done) begin
							state_q <= S_IDLE;
						end else if (!status.bld_small) begin
							state_q <= S_BWAIT;
						end
					end
					S_BWAIT: begin
						if (status.mul_done) begin
							state_q <= S_BCHK;
						end
					end
					S_IDLE: begin
						if (in_valid) begin
							state_q <= S_DISP;
						end
					end
					S_DISP: begin
						case (status.kind)
							mcu_pkg::K_POW: begin
								ret_q   <= R_POW;
								state_q <= S_PRED;
							end
							mcu_pkg::K_FACT: state_q <= S_FACT;
							mcu_pkg::K_PC: begin
								ret_q   <= R_INV1;
								state_q <= S_PRED;
							end
							default: state_q <= S_DONE;
						endcase
					end
					S_FACT:   state_q <= S_DONE;
					S_PRED:   state_q <= S_PRWAIT;
					S_PRWAIT: begin
						if (status.mul_done) begin
							state_q <= S_PCHK;
						end
					end
					S_PCHK: begin
						if (status.e_zero) begin
							case (ret_q)
								R_POW:   state_q <= S_VY;
								R_INV1:  state_q <= S_RDN;
								default: state_q <= S_MULVY;
							endcase
						end else if (status.e_lsb) begin
							state_q <= S_PYWAIT;
						end else begin
							state_q <= S_PSQ;
						end
					end
					S_PYWAIT: begin
						if (status.mul_done) begin
							state_q <= S_PSQ;
						end
					end
					S_PSQ:    state_q <= S_PBWAIT;
					S_PBWAIT: begin
						if (status.mul_done) begin
							state_q <= S_PCHK;
						end
					end
					S_VY:     state_q <= S_DONE;
					S_RDN:    state_q <= S_MULYRD;
					S_MULYRD: state_q <= S_MWAIT1;
					S_MWAIT1: begin
						if (status.mul_done) begin
							state_q <= status.choose ? S_RDR : S_DONE;
						end
					end
					S_RDR: begin
						ret_q   <= R_INV2;
						state_q <= S_PRED;
					end
					S_MULVY:  state_q <= S_MWAIT2;
					S_MWAIT2: begin
						if (status.mul_done) begin
							state_q <= S_DONE;
						end
					end
					S_DONE: begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_BINIT;
				endcase
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !status.cfg_wr;
	assign out_valid = out_valid_q;

endmodule

// File: sv/modular_combinatorics_unit.sv
// Factorials, powers, inverses, nPr, nCr and nHr modulo a programmable
// prime, one word at a time. All arithmetic runs on one shift-add modular
// multiplier; a power or inverse is a square-and-multiply loop over the
// exponent bits. nPr needs one inverse and nCr / nHr two, and factorial
// and the trivial cases need no product. After reset and after each
// modulus write the factorial table of MAX_N + 1 entries is rebuilt, one
// product per entry beyond the first two; no word is taken until it is
// done. The modulus register sits at byte address 0.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_combinatorics_unit
// Top level: stream ports, APB register port, controller and datapath.
// ---------------------------------------------------------------------------
module modular_combinatorics_unit #(
	parameter int unsigned MAX_N = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // func[2:0], arg_a[34:3], arg_b[66:35], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value[30:0], zero pad
	output logic [0:0]  m_tuser,   // range_error[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mcu_pkg::cmd_t    cmd;
	mcu_pkg::status_t status;
	logic             cfg_we;
	logic [31:0]      cfg_rdata;
	logic [30:0]      value;
	logic             range_error;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? cfg_rdata : 32'd0;

	mcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.cmd       (cmd),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	mcu_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.func        (s_tdata[2:0]),
		.arg_a       (s_tdata[34:3]),
		.arg_b       (s_tdata[66:35]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata),
		.cfg_rdata   (cfg_rdata),
		.value       (value),
		.range_error (range_error)
	);

	assign m_tdata = {1'b0, value};
	assign m_tuser = range_error;

endmodule
